// ===== design/tjs_pkg.sv =====
package tjs_pkg;

  localparam int MAX_JOBS_DEF   = 16;
  localparam int BURST_BITS_DEF = 8;

  localparam int ARR_W      = 8;
  localparam int SLOT_OUT_W = 4;
  localparam int LEFT_W     = 8;
  localparam int POL_W      = 2;
  localparam int QUANT_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [POL_W-1:0] POL_FCFS = 2'd0;
  localparam logic [POL_W-1:0] POL_RR   = 2'd1;
  localparam logic [POL_W-1:0] POL_SJF  = 2'd2;
  localparam logic [POL_W-1:0] POL_SRTF = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 1'd1;

  typedef struct packed {
    logic             arrival_valid;
    logic [ARR_W-1:0] arrival_burst;
  } tick_t;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] run_slot;
    logic [LEFT_W-1:0]     run_left;
    logic                  worked;
    logic                  all_done;
    logic                  arrival_dropped;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic scan_tail;
    logic rd_tgt;
    logic update;
    logic rd_fin;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/tjs_chan.sv =====
interface tjs_chan #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/tjs_ctrl.sv =====
module tjs_ctrl
  import tjs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_SCAN_END = 3'd2;
  localparam logic [2:0] S_RD_TGT   = 3'd3;
  localparam logic [2:0] S_UPD      = 3'd4;
  localparam logic [2:0] S_RD_FIN   = 3'd5;
  localparam logic [2:0] S_OUT      = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_next = S_SCAN_END;
      end
      S_SCAN_END: begin
        cmd.scan_tail = 1'b1;
        state_next    = S_RD_TGT;
      end
      S_RD_TGT: begin
        cmd.rd_tgt = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_RD_FIN;
      end
      S_RD_FIN: begin
        cmd.rd_fin = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

// ===== design/tjs_datapath.sv =====
module tjs_datapath
  import tjs_pkg::*;
#(
  parameter int MAX_JOBS   = MAX_JOBS_DEF,
  parameter int BURST_BITS = BURST_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  tick_t                 tick,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output result_t               out_data
);

  localparam int SW = $clog2(MAX_JOBS);
  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam int BW = BURST_BITS;
  localparam logic [CW-1:0] FULL      = CW'(MAX_JOBS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_JOBS - 1);
  localparam logic [BW-1:0] LEFT_CAP  = BW'((1 << LEFT_W) - 1);

  logic [BW-1:0] mem [MAX_JOBS];

  logic [POL_W-1:0]   policy;
  logic [QUANT_W-1:0] quantum;
  logic [CW-1:0]      count;
  logic [SW-1:0]      cur;
  logic [QUANT_W-1:0] slice;

  logic [SW-1:0] rd_addr;
  logic [BW-1:0] rd_data;
  logic          rd_ok;
  logic [BW-1:0] rd_val;

  logic [SW-1:0] scan_idx;
  logic [SW-1:0] scan_addr_d;
  logic          scan_pend;
  logic          found;
  logic [SW-1:0] min_idx;
  logic [BW-1:0] min_val;
  logic [CW-1:0] nz_count;

  logic [SW-1:0] tgt;
  logic [SW-1:0] tgt_r;
  logic          dropped_r;
  logic          worked_r;
  logic          done_r;

  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [BW-1:0] wr_data;

  logic               worked;
  logic               last_unit;
  logic [CW-1:0]      cur_inc;
  logic               has_next;
  logic [QUANT_W-1:0] q_eff;
  logic [QUANT_W:0]   slice_inc;
  logic               slice_end;
  logic               table_full;

  assign rd_val     = rd_ok ? rd_data : '0;
  assign table_full = (count == FULL);

  assign sts.scan_last = (scan_idx == LAST_SLOT);
  assign sts.out_free  = !out_valid || out_ready;

  // SRTF works the shortest slot, everything else works the current one
  assign tgt = (policy == POL_SRTF && found) ? min_idx : cur;

  always_comb begin
    if (cmd.scan)        rd_addr = scan_idx;
    else if (cmd.rd_tgt) rd_addr = tgt;
    else                 rd_addr = cur;
  end

  assign worked    = (rd_val != '0);
  assign last_unit = worked && (rd_val == BW'(1));
  assign cur_inc   = CW'(cur) + CW'(1);
  assign has_next  = (cur_inc < count);
  assign q_eff     = (quantum == '0) ? QUANT_W'(1) : quantum;
  assign slice_inc = {1'b0, slice} + (QUANT_W + 1)'(1);
  assign slice_end = (slice_inc >= {1'b0, q_eff});

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tgt_r;
    wr_data = rd_val - BW'(1);
    if (cmd.accept) begin
      wr_en   = tick.arrival_valid && !table_full;
      wr_addr = count[SW-1:0];
      wr_data = BW'(tick.arrival_burst);
    end else if (cmd.update) begin
      wr_en = worked;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // slots past the fill count read as empty
  always_ff @(posedge clk) begin
    rd_ok <= (CW'(rd_addr) < count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy  <= POL_FCFS;
      quantum <= QUANT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLICY:  policy  <= cfg_data[POL_W-1:0];
        REG_QUANTUM: quantum <= cfg_data[QUANT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cur   <= '0;
      slice <= '0;
    end else begin
      if (cmd.accept && tick.arrival_valid && !table_full) count <= count + CW'(1);
      if (cmd.update) begin
        case (policy)
          POL_FCFS: begin
            if (!worked && has_next) cur <= cur_inc[SW-1:0];
          end
          POL_RR: begin
            if (slice_end) begin
              slice <= '0;
              cur   <= has_next ? cur_inc[SW-1:0] : '0;
            end else begin
              slice <= slice_inc[QUANT_W-1:0];
            end
          end
          POL_SJF: begin
            if (!worked && found) cur <= min_idx;
          end
          default: begin
            if (found) cur <= min_idx;
          end
        endcase
      end
    end
  end

  // minimum scan, one table entry per cycle behind the read
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dropped_r <= tick.arrival_valid && table_full;
      scan_idx  <= '0;
      scan_pend <= 1'b0;
      found     <= 1'b0;
      nz_count  <= '0;
    end else begin
      if (cmd.scan) begin
        scan_idx    <= scan_idx + SW'(1);
        scan_addr_d <= scan_idx;
        scan_pend   <= 1'b1;
      end
      if ((cmd.scan || cmd.scan_tail) && scan_pend && rd_val != '0) begin
        nz_count <= nz_count + CW'(1);
        if (!found || rd_val < min_val) begin
          found   <= 1'b1;
          min_idx <= scan_addr_d;
          min_val <= rd_val;
        end
      end
    end
    if (cmd.rd_tgt) tgt_r <= tgt;
    if (cmd.update) begin
      worked_r <= worked;
      done_r   <= (nz_count - CW'(last_unit)) == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.run_slot        <= SLOT_OUT_W'(cur);
      out_data.run_left        <= (rd_val > LEFT_CAP) ? LEFT_W'(LEFT_CAP) : LEFT_W'(rd_val);
      out_data.worked          <= worked_r;
      out_data.all_done        <= done_r;
      out_data.arrival_dropped <= dropped_r;
    end
  end

endmodule

// ===== design/tick_job_scheduler.sv =====
// Tick-driven job scheduler. Each beat on ticks is one scheduler tick that may
// append a job burst to the next free table slot; the block then applies the
// selected policy (FCFS, round robin, SJF, SRTF) and returns one beat on
// results with the current slot, its remaining time and status flags. A tick
// passes from acceptance through the minimum scan, which reads the burst table
// memory one slot per cycle through its single read port, then through the
// read-modify-write of the worked slot and a read of the final slot. The next
// tick is accepted in the cycle after the result enters the output register.
// No clearing pass runs after reset: slots beyond the fill count read as empty.
// Write policy and quantum only while no tick is in flight.
module tick_job_scheduler
  import tjs_pkg::*;
#(
  parameter int MAX_JOBS   = MAX_JOBS_DEF,
  parameter int BURST_BITS = BURST_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  tjs_chan.sink                 ticks,
  tjs_chan.source               results,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  sts_t    sts;
  tick_t   tick;
  result_t res;

  assign tick         = ticks.data;
  assign results.data = res;

  tjs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ticks.valid),
    .in_ready (ticks.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tjs_datapath #(
    .MAX_JOBS   (MAX_JOBS),
    .BURST_BITS (BURST_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .tick      (tick),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .out_data  (res)
  );

endmodule

// ===== design/tjs_checker.sv =====
module tjs_props
  import tjs_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  logic [1:0] pend;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // ticks accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) pend <= '0;
    else     pend <= pend + 2'(in_acc) - 2'(out_acc);
  end

  a_one_tick_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("tick accepted while the previous one is in work");

  a_result_has_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pend != 2'd0)
    else $error("result beat without an accepted tick");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend != 2'd3)
    else $error("more than two ticks outstanding");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

endmodule

bind tick_job_scheduler tjs_props u_tjs_props (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (ticks.valid),
  .in_ready  (ticks.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  (results.data)
);
